### hdl/pwsc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwsc_pkg: shared types and constants of the presence wake/sleep controller
// Word layouts, zone and controller state codes, register map and reset
// values.
// ---------------------------------------------------------------------------
package pwsc_pkg;

   // Field widths
   localparam int RANGE_WIDTH   = 10;
   localparam int TIMER_WIDTH   = 16;
   localparam int CONFIRM_WIDTH = 8;
   localparam int STATE_WIDTH   = 3;
   localparam int ZONE_WIDTH    = 2;
   localparam int CSR_WIDTH     = 16;
   localparam int CSR_IDX_WIDTH = 3;

   // Register map
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_MIN_THRESHOLD     = 3'd0,
      CSR_ACTIVE_THRESHOLD  = 3'd1,
      CSR_ATTRACT_THRESHOLD = 3'd2,
      CSR_CONFIRM_TICKS     = 3'd3,
      CSR_WAKE_TICKS        = 3'd4,
      CSR_ABSENCE_TICKS     = 3'd5,
      CSR_SLEEP_TICKS       = 3'd6,
      CSR_FORCE_AWAKE       = 3'd7
   } csr_index_type;

   // Register reset values
   localparam logic [RANGE_WIDTH-1:0]   MIN_THRESHOLD_RST     = RANGE_WIDTH'(10);
   localparam logic [RANGE_WIDTH-1:0]   ACTIVE_THRESHOLD_RST  = RANGE_WIDTH'(60);
   localparam logic [RANGE_WIDTH-1:0]   ATTRACT_THRESHOLD_RST = RANGE_WIDTH'(150);
   localparam logic [CONFIRM_WIDTH-1:0] CONFIRM_TICKS_RST     = CONFIRM_WIDTH'(3);
   localparam logic [TIMER_WIDTH-1:0]   WAKE_TICKS_RST        = TIMER_WIDTH'(200);
   localparam logic [TIMER_WIDTH-1:0]   ABSENCE_TICKS_RST     = TIMER_WIDTH'(200);
   localparam logic [TIMER_WIDTH-1:0]   SLEEP_TICKS_RST       = TIMER_WIDTH'(200);

   // Committed / candidate zone codes
   typedef enum logic [ZONE_WIDTH-1:0] {
      ZONE_ABSENT  = 2'd0,
      ZONE_ATTRACT = 2'd1,
      ZONE_ACTIVE  = 2'd2,
      ZONE_MIN     = 2'd3
   } zone_type;

   // Reported system state codes
   localparam logic [STATE_WIDTH-1:0] CODE_ASLEEP   = 3'd0;
   localparam logic [STATE_WIDTH-1:0] CODE_ATTRACT  = 3'd1;
   localparam logic [STATE_WIDTH-1:0] CODE_WAKING   = 3'd2;
   localparam logic [STATE_WIDTH-1:0] CODE_AWAKE    = 3'd3;
   localparam logic [STATE_WIDTH-1:0] CODE_TO_SLEEP = 3'd4;

   // Controller state, one-hot
   typedef enum logic [4:0] {
      ST_ASLEEP   = 5'b00001,
      ST_ATTRACT  = 5'b00010,
      ST_WAKING   = 5'b00100,
      ST_AWAKE    = 5'b01000,
      ST_TO_SLEEP = 5'b10000
   } state_type;

   // Input word
   typedef struct packed {
      logic [RANGE_WIDTH-1:0] range_value;
      logic                   state_check;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [STATE_WIDTH-1:0] system_state;
      logic [ZONE_WIDTH-1:0]  zone;
      logic                   state_changed;
      logic [TIMER_WIDTH-1:0] ticks_left;
   } rsp_word_type;

   // Map the one-hot state onto its reported code
   function automatic logic [STATE_WIDTH-1:0] state_code(input state_type st);
      logic [STATE_WIDTH-1:0] code;
      unique case (st)
         ST_ASLEEP:   code = CODE_ASLEEP;
         ST_ATTRACT:  code = CODE_ATTRACT;
         ST_WAKING:   code = CODE_WAKING;
         ST_AWAKE:    code = CODE_AWAKE;
         ST_TO_SLEEP: code = CODE_TO_SLEEP;
         default:     code = CODE_ASLEEP;
      endcase
      return code;
   endfunction

   // Saturating tick counter step
   function automatic logic [TIMER_WIDTH-1:0] timer_advance(input logic [TIMER_WIDTH-1:0] t);
      return (t == {TIMER_WIDTH{1'b1}}) ? t : t + TIMER_WIDTH'(1);
   endfunction

   // Time remaining on a countdown, zero once expired
   function automatic logic [TIMER_WIDTH-1:0] timer_left(input logic [TIMER_WIDTH-1:0] elapsed,
                                                         input logic [TIMER_WIDTH-1:0] dur);
      return (elapsed < dur) ? dur - elapsed : '0;
   endfunction

endpackage

### hdl/presence_wake_sleep_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// presence_wake_sleep_controller: presence driven wake/sleep state machine
// Sorts range samples into zones, debounces the zone and steps a five-state
// wake/sleep controller with tick timers on state-check words.
// ---------------------------------------------------------------------------
//  channel | dir | handshake          | word
//  req     | in  | req_valid/req_stall | range_value, state_check
//  rsp     | out | rsp_valid/rsp_stall | system_state, zone, state_changed,
//          |     |                     | ticks_left
//  csr     | in  | csr_write           | csr_index, csr_data
//
// An accepted req word is held in the input register; its result is then
// registered in the result register, which raises rsp_valid. One word per
// cycle sustained while rsp is not stalled. The zone compare, debounce and
// controller step all sit between the input and result registers.
// Reset is synchronous and restores registers and controller state at once.
// A stall on rsp holds the result register and backs up into req_stall only
// when the input register is also full.
// ---------------------------------------------------------------------------
module presence_wake_sleep_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  pwsc_pkg::req_word_type                 req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output pwsc_pkg::rsp_word_type                 rsp_word,
   input  logic                                   csr_write,
   input  logic [pwsc_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [pwsc_pkg::CSR_WIDTH-1:0]         csr_data
);

   localparam int RW = pwsc_pkg::RANGE_WIDTH;
   localparam int TW = pwsc_pkg::TIMER_WIDTH;
   localparam int CW = pwsc_pkg::CONFIRM_WIDTH;

   // Configuration registers
   logic [RW-1:0] min_thr_ff, act_thr_ff, att_thr_ff;
   logic [CW-1:0] confirm_ticks_ff;
   logic [TW-1:0] wake_ticks_ff, absence_ticks_ff, sleep_ticks_ff;
   logic          force_awake_ff;

   // Pipeline registers
   logic                   in_valid_ff;
   pwsc_pkg::req_word_type in_word_ff;
   logic                   out_valid_ff;
   pwsc_pkg::rsp_word_type out_word_ff, out_word_in;

   // Controller state
   pwsc_pkg::zone_type  committed_ff, committed_in;
   pwsc_pkg::zone_type  pending_ff, pending_in;
   logic [CW-1:0]       confirm_cnt_ff, confirm_cnt_in;
   pwsc_pkg::state_type state_ff, state_in;
   logic [TW-1:0]       wake_el_ff, wake_el_in;
   logic [TW-1:0]       abs_el_ff, abs_el_in;
   logic [TW-1:0]       sleep_el_ff, sleep_el_in;
   logic                abs_run_ff, abs_run_in;

   logic advance;
   logic req_accept;

   assign advance    = !out_valid_ff || !rsp_stall;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_word   = out_word_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_thr_ff       <= pwsc_pkg::MIN_THRESHOLD_RST;
         act_thr_ff       <= pwsc_pkg::ACTIVE_THRESHOLD_RST;
         att_thr_ff       <= pwsc_pkg::ATTRACT_THRESHOLD_RST;
         confirm_ticks_ff <= pwsc_pkg::CONFIRM_TICKS_RST;
         wake_ticks_ff    <= pwsc_pkg::WAKE_TICKS_RST;
         absence_ticks_ff <= pwsc_pkg::ABSENCE_TICKS_RST;
         sleep_ticks_ff   <= pwsc_pkg::SLEEP_TICKS_RST;
         force_awake_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (pwsc_pkg::csr_index_type'(csr_index))
            pwsc_pkg::CSR_MIN_THRESHOLD:     min_thr_ff       <= csr_data[RW-1:0];
            pwsc_pkg::CSR_ACTIVE_THRESHOLD:  act_thr_ff       <= csr_data[RW-1:0];
            pwsc_pkg::CSR_ATTRACT_THRESHOLD: att_thr_ff       <= csr_data[RW-1:0];
            pwsc_pkg::CSR_CONFIRM_TICKS:     confirm_ticks_ff <= csr_data[CW-1:0];
            pwsc_pkg::CSR_WAKE_TICKS:        wake_ticks_ff    <= csr_data[TW-1:0];
            pwsc_pkg::CSR_ABSENCE_TICKS:     absence_ticks_ff <= csr_data[TW-1:0];
            pwsc_pkg::CSR_SLEEP_TICKS:       sleep_ticks_ff   <= csr_data[TW-1:0];
            pwsc_pkg::CSR_FORCE_AWAKE:       force_awake_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // One tick: timers, zone sort, debounce, controller step
   always_comb begin
      pwsc_pkg::zone_type  cand;
      pwsc_pkg::zone_type  z;
      pwsc_pkg::state_type nxt;
      logic                close_z;
      logic [TW-1:0]       tl;
      logic                changed;

      wake_el_in  = pwsc_pkg::timer_advance(wake_el_ff);
      abs_el_in   = pwsc_pkg::timer_advance(abs_el_ff);
      sleep_el_in = pwsc_pkg::timer_advance(sleep_el_ff);
      abs_run_in  = abs_run_ff;
      tl          = '0;
      changed     = 1'b0;

      // zone sort, nearest threshold first
      priority if (in_word_ff.range_value <= min_thr_ff) cand = pwsc_pkg::ZONE_MIN;
      else if (in_word_ff.range_value <= act_thr_ff)     cand = pwsc_pkg::ZONE_ACTIVE;
      else if (in_word_ff.range_value <= att_thr_ff)     cand = pwsc_pkg::ZONE_ATTRACT;
      else                                               cand = pwsc_pkg::ZONE_ABSENT;

      // debounce with saturating count
      committed_in = committed_ff;
      if (cand == pending_ff) begin
         pending_in     = pending_ff;
         confirm_cnt_in = (confirm_cnt_ff == {CW{1'b1}}) ? confirm_cnt_ff
                                                         : confirm_cnt_ff + CW'(1);
         if (confirm_cnt_in >= confirm_ticks_ff) begin
            committed_in = cand;
         end
      end else begin
         pending_in     = cand;
         confirm_cnt_in = CW'(1);
      end

      z       = committed_in;
      close_z = (z == pwsc_pkg::ZONE_ACTIVE) || (z == pwsc_pkg::ZONE_MIN);
      nxt     = state_ff;

      // controller step on state-check words
      if (in_word_ff.state_check) begin
         if (force_awake_ff) begin
            nxt = pwsc_pkg::ST_AWAKE;
         end else begin
            unique case (state_ff)
               pwsc_pkg::ST_ASLEEP: begin
                  if (z == pwsc_pkg::ZONE_ATTRACT) nxt = pwsc_pkg::ST_ATTRACT;
                  else if (close_z)                nxt = pwsc_pkg::ST_WAKING;
               end
               pwsc_pkg::ST_ATTRACT: begin
                  if (close_z) begin
                     nxt = pwsc_pkg::ST_WAKING;
                  end else if (z == pwsc_pkg::ZONE_ABSENT) begin
                     sleep_el_in = '0;
                     nxt         = pwsc_pkg::ST_TO_SLEEP;
                  end
               end
               pwsc_pkg::ST_WAKING: begin
                  if (z == pwsc_pkg::ZONE_ABSENT)       nxt = pwsc_pkg::ST_ASLEEP;
                  else if (z == pwsc_pkg::ZONE_ATTRACT) nxt = pwsc_pkg::ST_ATTRACT;
                  else if (wake_el_in >= wake_ticks_ff) nxt = pwsc_pkg::ST_AWAKE;
               end
               pwsc_pkg::ST_AWAKE: begin
                  if (z == pwsc_pkg::ZONE_ATTRACT) begin
                     nxt = pwsc_pkg::ST_ATTRACT;
                  end else if (close_z) begin
                     abs_run_in = 1'b0;
                  end else begin
                     // absence countdown; a stale running flag keeps the old count
                     if (!abs_run_ff) begin
                        abs_el_in  = '0;
                        abs_run_in = 1'b1;
                     end
                     tl = pwsc_pkg::timer_left(abs_el_in, absence_ticks_ff);
                     if (abs_el_in >= absence_ticks_ff) begin
                        sleep_el_in = '0;
                        nxt         = pwsc_pkg::ST_TO_SLEEP;
                     end
                  end
               end
               pwsc_pkg::ST_TO_SLEEP: begin
                  if (z == pwsc_pkg::ZONE_ATTRACT) begin
                     nxt = pwsc_pkg::ST_ATTRACT;
                  end else if (close_z) begin
                     nxt = pwsc_pkg::ST_WAKING;
                  end else begin
                     tl = pwsc_pkg::timer_left(sleep_el_in, sleep_ticks_ff);
                     if (sleep_el_in >= sleep_ticks_ff) nxt = pwsc_pkg::ST_ASLEEP;
                  end
               end
               default: nxt = state_ff;
            endcase
         end
         if (nxt != state_ff) begin
            changed = 1'b1;
            if (nxt == pwsc_pkg::ST_WAKING) wake_el_in = '0;
         end
      end

      state_in                  = nxt;
      out_word_in.system_state  = pwsc_pkg::state_code(nxt);
      out_word_in.zone          = z;
      out_word_in.state_changed = changed;
      out_word_in.ticks_left    = tl;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_word_ff <= req_word;
      end
   end

   // Result register and controller state update
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         committed_ff   <= pwsc_pkg::ZONE_ABSENT;
         pending_ff     <= pwsc_pkg::ZONE_ABSENT;
         confirm_cnt_ff <= '0;
         state_ff       <= pwsc_pkg::ST_ASLEEP;
         wake_el_ff     <= '0;
         abs_el_ff      <= '0;
         sleep_el_ff    <= '0;
         abs_run_ff     <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            committed_ff   <= committed_in;
            pending_ff     <= pending_in;
            confirm_cnt_ff <= confirm_cnt_in;
            state_ff       <= state_in;
            wake_el_ff     <= wake_el_in;
            abs_el_ff      <= abs_el_in;
            sleep_el_ff    <= sleep_el_in;
            abs_run_ff     <= abs_run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule

### hdl/pwsc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwsc_checker: port-level checks for the presence wake/sleep controller
// Watches the top-level ports only; attached by bind.
// ---------------------------------------------------------------------------
module pwsc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input pwsc_pkg::req_word_type             req_word,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input pwsc_pkg::rsp_word_type             rsp_word,
   input logic                               csr_write,
   input logic [pwsc_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input logic [pwsc_pkg::CSR_WIDTH-1:0]     csr_data
);

   // A stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // Nothing comes out in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // A countdown shows only while awake or going to sleep with the zone absent
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.ticks_left != '0) |->
         (rsp_word.zone == pwsc_pkg::ZONE_ABSENT) && !rsp_word.state_changed &&
         ((rsp_word.system_state == pwsc_pkg::CODE_AWAKE) ||
          (rsp_word.system_state == pwsc_pkg::CODE_TO_SLEEP)))
      else $error("ticks_left reported outside a countdown");

   // Waking up is entered only with a close zone
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.state_changed &&
         (rsp_word.system_state == pwsc_pkg::CODE_WAKING) |->
         (rsp_word.zone == pwsc_pkg::ZONE_ACTIVE) || (rsp_word.zone == pwsc_pkg::ZONE_MIN))
      else $error("entered waking up without a close zone");

endmodule

bind presence_wake_sleep_controller pwsc_checker u_pwsc_checker (.*);

### sim/presence_wake_sleep_controller_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// presence_wake_sleep_controller_tb: self-checking bench for the controller
// A short directed plan (ticks and register writes) runs first. Random
// register settings and tick streams follow, shaped as runs of one zone.
// Long runs push the debounce count to its limit. Each result word is
// compared field by field against an in-bench model of zone debounce, the
// five-state controller and its tick timers, or against the plan's typed
// values. Both channels idle and stall at random, but for phases 2 and 3.
// ---------------------------------------------------------------------------
module presence_wake_sleep_controller_tb;

   localparam int RW             = pwsc_pkg::RANGE_WIDTH;
   localparam int CW             = pwsc_pkg::CONFIRM_WIDTH;
   localparam int TW             = pwsc_pkg::TIMER_WIDTH;
   localparam int SW             = pwsc_pkg::STATE_WIDTH;
   localparam int DW             = pwsc_pkg::CSR_WIDTH;
   localparam int IDLE_PCT       = 35;
   localparam int NUM_PHASES     = 20;
   localparam int PHASE_ITEMS    = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int REG_WIDTH [8]  = '{RW, RW, RW, CW, TW, TW, TW, 1};

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      pwsc_pkg::req_word_type  word;
      logic                    typed;
      pwsc_pkg::rsp_word_type  result;
      pwsc_pkg::csr_index_type idx;
      logic [DW-1:0]           data;
   } plan_row_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   pwsc_pkg::req_word_type               req_word;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   pwsc_pkg::rsp_word_type               rsp_word;
   logic                                 csr_write;
   logic [pwsc_pkg::CSR_IDX_WIDTH-1:0]   csr_index;
   logic [DW-1:0]                        csr_data;

   plan_row_type           plan[$];
   pwsc_pkg::rsp_word_type result_q[$];
   int                     fail_count;
   int                     stuck_cycles;
   logic                   idle_on;

   // Model copy of the registers
   logic [RW-1:0] min_th, act_th, att_th;
   logic [CW-1:0] confirm_len;
   logic [TW-1:0] wake_dur, absence_dur, sleep_dur;
   logic          force_on;

   // Model copy of the controller state
   pwsc_pkg::zone_type committed_z, pending_z;
   logic [CW-1:0]      confirm_cnt;
   logic [SW-1:0]      ctl_state;
   logic [TW-1:0]      wake_el, absence_el, sleep_el;
   logic               absence_run;

   presence_wake_sleep_controller DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // One tick of the controller: timers, zone debounce, then state step
   function automatic pwsc_pkg::rsp_word_type predict_tick(input pwsc_pkg::req_word_type w);
      pwsc_pkg::rsp_word_type r;
      pwsc_pkg::zone_type     cand;
      logic [SW-1:0]          nxt;
      logic [TW-1:0]          remain;
      logic                   near;
      logic                   changed;
      remain  = '0;
      changed = 1'b0;
      if (wake_el != '1) wake_el = wake_el + 1'b1;
      if (absence_el != '1) absence_el = absence_el + 1'b1;
      if (sleep_el != '1) sleep_el = sleep_el + 1'b1;

      if (w.range_value <= min_th) cand = pwsc_pkg::ZONE_MIN;
      else if (w.range_value <= act_th) cand = pwsc_pkg::ZONE_ACTIVE;
      else if (w.range_value <= att_th) cand = pwsc_pkg::ZONE_ATTRACT;
      else cand = pwsc_pkg::ZONE_ABSENT;

      if (cand == pending_z) begin
         if (confirm_cnt != 8'd255) confirm_cnt = confirm_cnt + 1'b1;
         if (confirm_cnt >= confirm_len) committed_z = cand;
      end else begin
         pending_z   = cand;
         confirm_cnt = 8'd1;
      end

      near = (committed_z == pwsc_pkg::ZONE_ACTIVE) || (committed_z == pwsc_pkg::ZONE_MIN);
      if (w.state_check) begin
         nxt = ctl_state;
         if (force_on) begin
            nxt = pwsc_pkg::CODE_AWAKE;
         end else begin
            case (ctl_state)
               pwsc_pkg::CODE_ASLEEP: begin
                  if (committed_z == pwsc_pkg::ZONE_ATTRACT) nxt = pwsc_pkg::CODE_ATTRACT;
                  else if (near) nxt = pwsc_pkg::CODE_WAKING;
               end
               pwsc_pkg::CODE_ATTRACT: begin
                  if (near) begin
                     nxt = pwsc_pkg::CODE_WAKING;
                  end else if (committed_z == pwsc_pkg::ZONE_ABSENT) begin
                     sleep_el = '0;
                     nxt      = pwsc_pkg::CODE_TO_SLEEP;
                  end
               end
               pwsc_pkg::CODE_WAKING: begin
                  if (committed_z == pwsc_pkg::ZONE_ABSENT) nxt = pwsc_pkg::CODE_ASLEEP;
                  else if (committed_z == pwsc_pkg::ZONE_ATTRACT) nxt = pwsc_pkg::CODE_ATTRACT;
                  else if (wake_el >= wake_dur) nxt = pwsc_pkg::CODE_AWAKE;
               end
               pwsc_pkg::CODE_AWAKE: begin
                  if (committed_z == pwsc_pkg::ZONE_ATTRACT) begin
                     nxt = pwsc_pkg::CODE_ATTRACT;
                  end else if (near) begin
                     absence_run = 1'b0;
                  end else begin
                     // a stale run flag keeps the old absence count
                     if (!absence_run) begin
                        absence_el  = '0;
                        absence_run = 1'b1;
                     end
                     remain = (absence_el < absence_dur) ? absence_dur - absence_el : '0;
                     if (absence_el >= absence_dur) begin
                        sleep_el = '0;
                        nxt      = pwsc_pkg::CODE_TO_SLEEP;
                     end
                  end
               end
               pwsc_pkg::CODE_TO_SLEEP: begin
                  if (committed_z == pwsc_pkg::ZONE_ATTRACT) begin
                     nxt = pwsc_pkg::CODE_ATTRACT;
                  end else if (near) begin
                     nxt = pwsc_pkg::CODE_WAKING;
                  end else begin
                     remain = (sleep_el < sleep_dur) ? sleep_dur - sleep_el : '0;
                     if (sleep_el >= sleep_dur) nxt = pwsc_pkg::CODE_ASLEEP;
                  end
               end
               default: ;
            endcase
         end
         if (nxt != ctl_state) begin
            changed = 1'b1;
            if (nxt == pwsc_pkg::CODE_WAKING) wake_el = '0;
            ctl_state = nxt;
         end
      end

      r.system_state  = ctl_state;
      r.zone          = committed_z;
      r.state_changed = changed;
      r.ticks_left    = remain;
      return r;
   endfunction

   // Directed plan builders
   function automatic void add_tick(input logic [RW-1:0] rv, input logic chk);
      plan_row_type row;
      row                   = '0;
      row.kind              = ROW_TICK;
      row.word.range_value  = rv;
      row.word.state_check  = chk;
      plan.push_back(row);
   endfunction

   function automatic void add_typed(input logic [RW-1:0] rv, input logic chk,
                                     input logic [SW-1:0] st, input pwsc_pkg::zone_type zn,
                                     input logic chg);
      plan_row_type row;
      row                      = '0;
      row.kind                 = ROW_TICK;
      row.word.range_value     = rv;
      row.word.state_check     = chk;
      row.typed                = 1'b1;
      row.result.system_state  = st;
      row.result.zone          = zn;
      row.result.state_changed = chg;
      plan.push_back(row);
   endfunction

   function automatic void add_write(input pwsc_pkg::csr_index_type idx,
                                     input logic [DW-1:0] data);
      plan_row_type row;
      row      = '0;
      row.kind = ROW_WRITE;
      row.idx  = idx;
      row.data = data;
      plan.push_back(row);
   endfunction

   // Present one word, wait for it to be taken, record what it should give
   task automatic send_tick(input pwsc_pkg::req_word_type w, input logic typed,
                            input pwsc_pkg::rsp_word_type typed_word);
      pwsc_pkg::rsp_word_type predicted;
      if (csr_write) csr_write <= 1'b0;
      while (idle_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_tick(w);
      result_q.push_back(typed ? typed_word : predicted);
   endtask

   // Stop sending and let every outstanding result drain
   task automatic settle();
      req_valid <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);
   endtask

   // Register write; the caller's next word lowers the strobe
   task automatic write_reg(input pwsc_pkg::csr_index_type idx, input logic [DW-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      case (idx)
         pwsc_pkg::CSR_MIN_THRESHOLD:     min_th      = data[RW-1:0];
         pwsc_pkg::CSR_ACTIVE_THRESHOLD:  act_th      = data[RW-1:0];
         pwsc_pkg::CSR_ATTRACT_THRESHOLD: att_th      = data[RW-1:0];
         pwsc_pkg::CSR_CONFIRM_TICKS:     confirm_len = data[CW-1:0];
         pwsc_pkg::CSR_WAKE_TICKS:        wake_dur    = data[TW-1:0];
         pwsc_pkg::CSR_ABSENCE_TICKS:     absence_dur = data[TW-1:0];
         pwsc_pkg::CSR_SLEEP_TICKS:       sleep_dur   = data[TW-1:0];
         pwsc_pkg::CSR_FORCE_AWAKE:       force_on    = data[0];
         default: ;
      endcase
   endtask

   // Register setting of one random phase: extremes first, then mostly short timers
   task automatic program_phase(input int k);
      logic [DW-1:0] val [8];
      logic [DW-1:0] data;
      logic [DW-1:0] mask;
      if (k == 0) begin
         val = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0};
      end else if (k == 1) begin
         val = '{16'd1023, 16'd1023, 16'd1023, 16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1};
      end else begin
         val[0] = DW'($urandom_range(0, 300));
         val[1] = val[0] + DW'($urandom_range(0, 300));
         val[2] = val[1] + DW'($urandom_range(0, 400));
         if ($urandom_range(0, 4) == 0) begin
            for (int i = 0; i < 3; i++) val[i] = DW'($urandom_range(0, 1023));
         end
         val[3] = ($urandom_range(0, 9) < 8) ? DW'($urandom_range(1, 4))
                                             : DW'($urandom_range(1, 255));
         for (int i = 4; i < 7; i++) begin
            case ($urandom_range(0, 9))
               0:       val[i] = 16'hFFFF;
               1:       val[i] = DW'($urandom_range(13, 400));
               default: val[i] = DW'($urandom_range(1, 12));
            endcase
         end
         val[7] = DW'($urandom_range(0, 9) == 0);
      end
      for (int i = 0; i < 8; i++) begin
         // bits above the register width are dropped
         mask = DW'((32'd1 << REG_WIDTH[i]) - 32'd1);
         data = val[i];
         if ($urandom_range(0, 3) == 0) data = data | (DW'($urandom()) & ~mask);
         write_reg(pwsc_pkg::csr_index_type'(i), data);
      end
   endtask

   // Result side: random stall, compare each taken word with the oldest expectation
   always @(posedge clock) begin
      pwsc_pkg::rsp_word_type want;
      rsp_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (result_q.size() == 0) begin
            $error("unexpected result word %h", rsp_word);
            fail_count++;
         end else begin
            want = result_q.pop_front();
            if (rsp_word.system_state !== want.system_state) begin
               $error("system_state: expected %0d, got %0d",
                      want.system_state, rsp_word.system_state);
               fail_count++;
            end
            if (rsp_word.zone !== want.zone) begin
               $error("zone: expected %0d, got %0d", want.zone, rsp_word.zone);
               fail_count++;
            end
            if (rsp_word.state_changed !== want.state_changed) begin
               $error("state_changed: expected %0d, got %0d",
                      want.state_changed, rsp_word.state_changed);
               fail_count++;
            end
            if (rsp_word.ticks_left !== want.ticks_left) begin
               $error("ticks_left: expected %0d, got %0d", want.ticks_left, rsp_word.ticks_left);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("presence_wake_sleep_controller_tb NOT OK");
         $finish;
      end
   end

   initial begin
      pwsc_pkg::req_word_type w;
      logic [RW-1:0]          target;
      int                     n;
      int                     len;

      idle_on      = 1'b1;
      min_th       = pwsc_pkg::MIN_THRESHOLD_RST;
      act_th       = pwsc_pkg::ACTIVE_THRESHOLD_RST;
      att_th       = pwsc_pkg::ATTRACT_THRESHOLD_RST;
      confirm_len  = pwsc_pkg::CONFIRM_TICKS_RST;
      wake_dur     = pwsc_pkg::WAKE_TICKS_RST;
      absence_dur  = pwsc_pkg::ABSENCE_TICKS_RST;
      sleep_dur    = pwsc_pkg::SLEEP_TICKS_RST;
      force_on     = 1'b0;
      committed_z  = pwsc_pkg::ZONE_ABSENT;
      pending_z    = pwsc_pkg::ZONE_ABSENT;
      confirm_cnt  = '0;
      ctl_state    = pwsc_pkg::CODE_ASLEEP;
      wake_el      = '0;
      absence_el   = '0;
      sleep_el     = '0;
      absence_run  = 1'b0;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;

      // Right after reset: three equal ticks commit a zone
      add_typed(10'd1023, 1'b1, pwsc_pkg::CODE_ASLEEP, pwsc_pkg::ZONE_ABSENT, 1'b0);
      add_typed(10'd1023, 1'b0, pwsc_pkg::CODE_ASLEEP, pwsc_pkg::ZONE_ABSENT, 1'b0);
      add_typed(10'd0,    1'b0, pwsc_pkg::CODE_ASLEEP, pwsc_pkg::ZONE_ABSENT, 1'b0);
      add_typed(10'd0,    1'b0, pwsc_pkg::CODE_ASLEEP, pwsc_pkg::ZONE_ABSENT, 1'b0);
      add_typed(10'd0,    1'b1, pwsc_pkg::CODE_WAKING, pwsc_pkg::ZONE_MIN,    1'b1);
      // Short timers, one-tick confirm; upper data bits are dropped
      add_write(pwsc_pkg::CSR_CONFIRM_TICKS, 16'd1);
      add_write(pwsc_pkg::CSR_WAKE_TICKS, 16'd1);
      add_write(pwsc_pkg::CSR_ABSENCE_TICKS, 16'd2);
      add_write(pwsc_pkg::CSR_SLEEP_TICKS, 16'd2);
      add_write(pwsc_pkg::CSR_MIN_THRESHOLD, 16'hFC0A);
      add_tick(10'd10, 1'b1);
      add_tick(10'd11, 1'b1);
      add_tick(10'd60, 1'b1);
      // Awake, zone goes absent: absence countdown, then going to sleep, then asleep
      add_tick(10'd151, 1'b1);
      add_tick(10'd151, 1'b1);
      add_tick(10'd1023, 1'b1);
      add_tick(10'd1023, 1'b1);
      add_tick(10'd1023, 1'b0);
      add_tick(10'd1023, 1'b1);
      // Attract, then absent, then close again
      add_tick(10'd150, 1'b1);
      add_tick(10'd150, 1'b1);
      add_tick(10'd1023, 1'b1);
      add_tick(10'd1023, 1'b1);
      add_tick(10'd0, 1'b1);
      add_tick(10'd0, 1'b1);
      add_tick(10'd0, 1'b1);
      // Absence run flag left set through attract is not restarted
      add_tick(10'd1023, 1'b1);
      add_tick(10'd1023, 1'b1);
      add_tick(10'd100, 1'b1);
      add_tick(10'd100, 1'b1);
      add_tick(10'd0, 1'b1);
      add_tick(10'd0, 1'b1);
      add_tick(10'd1023, 1'b1);
      add_tick(10'd1023, 1'b1);
      // Force awake on, then off through a write with junk upper bits
      add_write(pwsc_pkg::CSR_FORCE_AWAKE, 16'h0001);
      add_tick(10'd1023, 1'b1);
      add_write(pwsc_pkg::CSR_FORCE_AWAKE, 16'hFFFE);
      add_tick(10'd1023, 1'b1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            settle();
            write_reg(plan[i].idx, plan[i].data);
         end else begin
            send_tick(plan[i].word, plan[i].typed, plan[i].result);
         end
      end

      // Random phases: runs of one range value, with some noise words
      for (int k = 0; k < NUM_PHASES; k++) begin
         settle();
         program_phase(k);
         idle_on = !(k == 2 || k == 3);
         n = 0;
         while (n < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 15) begin
               w.range_value = RW'($urandom_range(0, 1023));
               w.state_check = 1'($urandom_range(0, 1));
               send_tick(w, 1'b0, '0);
               n++;
            end else begin
               case ($urandom_range(0, 7))
                  0:       target = min_th;
                  1:       target = min_th + 1'b1;
                  2:       target = act_th;
                  3:       target = act_th + 1'b1;
                  4:       target = att_th;
                  5:       target = att_th + 1'b1;
                  6:       target = $urandom_range(0, 1) ? '0 : '1;
                  default: target = RW'($urandom_range(0, 1023));
               endcase
               len = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 300)
                                                   : $urandom_range(1, 14);
               repeat (len) begin
                  w.range_value = target;
                  w.state_check = ($urandom_range(0, 99) < 85);
                  send_tick(w, 1'b0, '0);
                  n++;
               end
            end
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("presence_wake_sleep_controller_tb OK");
      else
         $display("presence_wake_sleep_controller_tb NOT OK");
      $finish;
   end

endmodule
